// ===== rtl/core/juu_pkg.sv =====
// ----------------------------------------------------------------------------
// juu_pkg: shared definitions for the JSON string unescaper
// Result status codes and the source characters that the parser tests.
// ----------------------------------------------------------------------------
package juu_pkg;

  // Result status codes
  localparam logic [3:0] ST_DATA     = 4'd0;
  localparam logic [3:0] ST_CLOSED   = 4'd1;
  localparam logic [3:0] ST_NO_QUOTE = 4'd2;
  localparam logic [3:0] ST_UNTERM   = 4'd3;
  localparam logic [3:0] ST_CONTROL  = 4'd4;
  localparam logic [3:0] ST_BAD_ESC  = 4'd5;
  localparam logic [3:0] ST_BAD_HEX  = 4'd6;
  localparam logic [3:0] ST_UNPAIRED = 4'd7;
  localparam logic [3:0] ST_BAD_LOW  = 4'd8;
  localparam logic [3:0] ST_LONE_LOW = 4'd9;
  localparam logic [3:0] ST_SHORT_U  = 4'd10;

  // Source characters
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CH_SPACE  = 8'h20;

  // Bytes that escapes stand for
  localparam logic [7:0] BY_BS  = 8'h08;
  localparam logic [7:0] BY_FF  = 8'h0C;
  localparam logic [7:0] BY_LF  = 8'h0A;
  localparam logic [7:0] BY_CR  = 8'h0D;
  localparam logic [7:0] BY_TAB = 8'h09;

  // Surrogate prefixes (top six bits of a code unit)
  localparam logic [5:0] SURR_HIGH = 6'b110110;
  localparam logic [5:0] SURR_LOW  = 6'b110111;

  // Most result bytes that one source byte can cause
  localparam int unsigned MAX_RES = 4;

endpackage

// ===== rtl/core/juu_src_if.sv =====
// ----------------------------------------------------------------------------
// juu_src_if: source byte channel
// Valid/ready channel that carries one source byte or an end-of-source event.
// ----------------------------------------------------------------------------
interface juu_src_if;
  logic       valid;
  logic       ready;
  logic [7:0] source_byte;
  logic       end_of_source;

  modport source (output valid, output source_byte, output end_of_source, input ready);
  modport sink   (input valid, input source_byte, input end_of_source, output ready);
endinterface

// ===== rtl/core/juu_res_if.sv =====
// ----------------------------------------------------------------------------
// juu_res_if: result channel
// Valid/ready channel that carries one decoded byte or a status per transaction.
// ----------------------------------------------------------------------------
interface juu_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [3:0] status;
  logic       last_of_run;

  modport source (output valid, output out_byte, output status, output last_of_run,
                  input ready);
  modport sink   (input valid, input out_byte, input status, input last_of_run,
                  output ready);
endinterface

// ===== rtl/core/json_string_unescape_utf8_unit.sv =====
// ----------------------------------------------------------------------------
// json_string_unescape_utf8_unit: JSON string unescaper with UTF-8 output
// Parses one quoted JSON string per run and emits decoded bytes or a status.
// ----------------------------------------------------------------------------
// The unit takes one source byte (or an end-of-source event) per transaction
// on src_i and emits its results on res_o, one per transaction, with
// last_of_run marking the final result of each source transaction. An
// accepted item lands in an input register; the parser decodes it against its
// state and, once the burst register is free, loads it with zero to four
// results. Plain bytes, simple escapes and one-byte code points therefore
// sustain one source byte per cycle while res_o is ready; a \u escape that
// yields an N-byte UTF-8 sequence holds the next source byte in the input
// register while the burst register drains, and the burst register holds
// one burst at a time. Errors and the closing quote give one status result
// each and send the parser back to waiting for an opening quote.
// ----------------------------------------------------------------------------
module json_string_unescape_utf8_unit (
  input  logic clk_i,
  input  logic rst_ni,
  juu_src_if.sink   src_i,
  juu_res_if.source res_o
);
  import juu_pkg::*;

  typedef enum logic [2:0] {
    M_WAIT,
    M_STR,
    M_ESC,
    M_HEX,
    M_PAIR_BS,
    M_PAIR_U,
    M_LOW_HEX
  } mode_e;

  // Parser state
  mode_e       mode_q, mode_d;
  logic [2:0]  hex_cnt_q, hex_cnt_d;
  logic [15:0] accum_q, accum_d;
  logic [9:0]  high_q, high_d;

  // Input register
  logic        in_vld_q;
  logic [7:0]  in_byte_q;
  logic        in_end_q;

  // Result burst register
  logic [7:0]  bst_byte_q [MAX_RES];
  logic [3:0]  bst_status_q;
  logic [2:0]  bst_cnt_q;
  logic [1:0]  bst_idx_q;

  // Decode results
  logic [7:0]  r_byte [MAX_RES];
  logic [3:0]  r_status;
  logic [2:0]  r_cnt;

  logic        in_fire, out_fire, out_last, load_ok, move;

  // Hex and code point helpers
  logic [3:0]  hval;
  logic        hok;
  logic [15:0] acc_sh;
  logic [2:0]  cnt_inc;
  logic [20:0] cp;
  logic        emit_cp;

  assign out_last = ({1'b0, bst_idx_q} == (bst_cnt_q - 3'd1));
  assign out_fire = res_o.valid && res_o.ready;
  assign load_ok  = (bst_cnt_q == 3'd0) || (out_fire && out_last);
  assign move     = in_vld_q && load_ok;
  assign in_fire  = src_i.valid && src_i.ready;

  assign src_i.ready       = !in_vld_q || load_ok;
  assign res_o.valid       = (bst_cnt_q != 3'd0);
  assign res_o.out_byte    = bst_byte_q[bst_idx_q];
  assign res_o.status      = bst_status_q;
  assign res_o.last_of_run = out_last;

  // Decode the hex digit and form the shifted code unit
  always_comb begin
    hval = 4'd0;
    hok  = 1'b0;
    if (in_byte_q inside {[8'h30:8'h39]}) begin
      hval = in_byte_q[3:0];
      hok  = 1'b1;
    end else if (in_byte_q inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
      hval = in_byte_q[3:0] + 4'd9;
      hok  = 1'b1;
    end
    acc_sh  = {accum_q[11:0], hval};
    cnt_inc = hex_cnt_q + 3'd1;
  end

  // Parse one item against the state
  always_comb begin
    mode_d    = mode_q;
    hex_cnt_d = hex_cnt_q;
    accum_d   = accum_q;
    high_d    = high_q;
    r_status  = ST_DATA;
    r_cnt     = 3'd0;
    r_byte[0] = 8'd0;
    cp        = 21'd0;
    emit_cp   = 1'b0;

    if (in_end_q) begin
      r_cnt = 3'd1;
      case (mode_q)
        M_STR, M_ESC:                  r_status = ST_UNTERM;
        M_HEX:                         r_status = ST_SHORT_U;
        M_PAIR_BS, M_PAIR_U, M_LOW_HEX: r_status = ST_UNPAIRED;
        default:                       r_status = ST_NO_QUOTE;
      endcase
    end else begin
      case (mode_q)
        M_STR: begin
          if (in_byte_q == CH_QUOTE) begin
            r_cnt    = 3'd1;
            r_status = ST_CLOSED;
          end else if (in_byte_q < CH_SPACE) begin
            r_cnt    = 3'd1;
            r_status = ST_CONTROL;
          end else if (in_byte_q == CH_BSLASH) begin
            mode_d = M_ESC;
          end else begin
            r_cnt     = 3'd1;
            r_byte[0] = in_byte_q;
          end
        end
        M_ESC: begin
          mode_d = M_STR;
          r_cnt  = 3'd1;
          case (in_byte_q)
            CH_QUOTE, CH_BSLASH, CH_SLASH: r_byte[0] = in_byte_q;
            CH_B: r_byte[0] = BY_BS;
            CH_F: r_byte[0] = BY_FF;
            CH_N: r_byte[0] = BY_LF;
            CH_R: r_byte[0] = BY_CR;
            CH_T: r_byte[0] = BY_TAB;
            CH_U: begin
              r_cnt     = 3'd0;
              mode_d    = M_HEX;
              hex_cnt_d = 3'd0;
              accum_d   = 16'd0;
            end
            default: r_status = ST_BAD_ESC;
          endcase
        end
        M_HEX: begin
          if (!hok) begin
            r_cnt    = 3'd1;
            r_status = ST_BAD_HEX;
          end else if (!cnt_inc[2]) begin
            hex_cnt_d = cnt_inc;
            accum_d   = acc_sh;
          end else if (acc_sh[15:10] == SURR_HIGH) begin
            high_d    = acc_sh[9:0];
            hex_cnt_d = 3'd0;
            accum_d   = 16'd0;
            mode_d    = M_PAIR_BS;
          end else if (acc_sh[15:10] == SURR_LOW) begin
            r_cnt    = 3'd1;
            r_status = ST_LONE_LOW;
          end else begin
            cp        = {5'd0, acc_sh};
            emit_cp   = 1'b1;
            hex_cnt_d = 3'd0;
            accum_d   = 16'd0;
            mode_d    = M_STR;
          end
        end
        M_PAIR_BS: begin
          if (in_byte_q == CH_BSLASH) begin
            mode_d = M_PAIR_U;
          end else begin
            r_cnt    = 3'd1;
            r_status = ST_UNPAIRED;
          end
        end
        M_PAIR_U: begin
          if (in_byte_q == CH_U) begin
            mode_d    = M_LOW_HEX;
            hex_cnt_d = 3'd0;
            accum_d   = 16'd0;
          end else begin
            r_cnt    = 3'd1;
            r_status = ST_UNPAIRED;
          end
        end
        M_LOW_HEX: begin
          if (!hok) begin
            r_cnt    = 3'd1;
            r_status = ST_BAD_HEX;
          end else if (!cnt_inc[2]) begin
            hex_cnt_d = cnt_inc;
            accum_d   = acc_sh;
          end else if (acc_sh[15:10] != SURR_LOW) begin
            r_cnt    = 3'd1;
            r_status = ST_BAD_LOW;
          end else begin
            cp        = 21'h10000 + {1'b0, high_q, acc_sh[9:0]};
            emit_cp   = 1'b1;
            hex_cnt_d = 3'd0;
            accum_d   = 16'd0;
            high_d    = 10'd0;
            mode_d    = M_STR;
          end
        end
        default: begin
          if (in_byte_q != CH_QUOTE) begin
            r_cnt    = 3'd1;
            r_status = ST_NO_QUOTE;
          end
          mode_d = (in_byte_q == CH_QUOTE) ? M_STR : M_WAIT;
        end
      endcase
    end

    // Drop back to waiting after any status result
    if (r_cnt != 3'd0 && r_status != ST_DATA) begin
      mode_d    = M_WAIT;
      hex_cnt_d = 3'd0;
      accum_d   = 16'd0;
      high_d    = 10'd0;
    end

    // Encode a decoded code point as UTF-8
    r_byte[1] = {2'b10, cp[5:0]};
    r_byte[2] = {2'b10, cp[5:0]};
    r_byte[3] = {2'b10, cp[5:0]};
    if (emit_cp) begin
      if (cp < 21'h80) begin
        r_cnt     = 3'd1;
        r_byte[0] = cp[7:0];
      end else if (cp < 21'h800) begin
        r_cnt     = 3'd2;
        r_byte[0] = {3'b110, cp[10:6]};
      end else if (cp < 21'h10000) begin
        r_cnt     = 3'd3;
        r_byte[0] = {4'b1110, cp[15:12]};
        r_byte[1] = {2'b10, cp[11:6]};
      end else begin
        r_cnt     = 3'd4;
        r_byte[0] = {5'b11110, cp[20:18]};
        r_byte[1] = {2'b10, cp[17:12]};
        r_byte[2] = {2'b10, cp[11:6]};
      end
    end
  end

  // Hold parser state, input valid and burst position
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= M_WAIT;
      hex_cnt_q    <= 3'd0;
      accum_q      <= 16'd0;
      high_q       <= 10'd0;
      in_vld_q     <= 1'b0;
      bst_cnt_q    <= 3'd0;
      bst_idx_q    <= 2'd0;
      bst_status_q <= ST_DATA;
    end else begin
      if (in_fire) begin
        in_vld_q <= 1'b1;
      end else if (move) begin
        in_vld_q <= 1'b0;
      end
      if (move) begin
        mode_q       <= mode_d;
        hex_cnt_q    <= hex_cnt_d;
        accum_q      <= accum_d;
        high_q       <= high_d;
        bst_cnt_q    <= r_cnt;
        bst_idx_q    <= 2'd0;
        bst_status_q <= r_status;
      end else if (out_fire) begin
        if (out_last) begin
          bst_cnt_q <= 3'd0;
        end else begin
          bst_idx_q <= bst_idx_q + 2'd1;
        end
      end
    end
  end

  // Capture payload of the input and result registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_byte_q <= src_i.source_byte;
      in_end_q  <= src_i.end_of_source;
    end
    if (move) begin
      for (int i = 0; i < MAX_RES; i++) begin
        bst_byte_q[i] <= r_byte[i];
      end
    end
  end

endmodule

// ===== rtl/core/juu_checker.sv =====
// ----------------------------------------------------------------------------
// juu_checker: port-level checks for the JSON string unescaper
// Watches the source and result channels and flags burst and status slips.
// ----------------------------------------------------------------------------
module juu_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] out_byte_i,
  input logic [3:0] status_i,
  input logic       last_i
);
  import juu_pkg::*;

  // A status result always ends its run
  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i != ST_DATA |-> last_i)
    else $error("status result not marked last of run");

  // A status result carries a zero byte
  a_status_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i != ST_DATA |-> out_byte_i == 8'd0)
    else $error("status result carries a nonzero byte");

  // A multi-byte run continues with data in the next cycle
  a_burst_cont: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && !last_i |=> out_valid_i && status_i == ST_DATA)
    else $error("multi-byte run broken off");

  // A new transaction waits while a run is still mid-way and stalled
  a_hold_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i && in_valid_i && in_ready_i |=>
      !in_ready_i || (out_valid_i && last_i))
    else $error("source accepted beyond the input register");

endmodule

bind json_string_unescape_utf8_unit juu_checker u_juu_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (src_i.valid),
  .in_ready_i  (src_i.ready),
  .out_valid_i (res_o.valid),
  .out_ready_i (res_o.ready),
  .out_byte_i  (res_o.out_byte),
  .status_i    (res_o.status),
  .last_i      (res_o.last_of_run)
);

// ===== sim/tb_json_string_unescape_utf8_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_json_string_unescape_utf8_unit: testbench for the JSON string unescaper
// Feeds a short table of hand-picked source bytes, then random quoted strings
// with escapes, surrogate pairs and every kind of error ending. Table rows are
// checked against typed results or an untimed model of the parser, random
// results against the model, under random idling on both channels.
// ----------------------------------------------------------------------------
module tb_json_string_unescape_utf8_unit;
  import juu_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned RANDOM_ITEMS = 400;
  localparam int unsigned TAIL_CYCLES  = 16;
  localparam int unsigned N_ROWS       = 29;

  // Characters the generator needs beyond the package set
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_LC_A = 8'h61;
  localparam logic [7:0] CH_UC_A = 8'h41;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [3:0] status;
    logic       last_of_run;
  } result_t;

  typedef enum logic [2:0] {
    SCAN_WAIT, SCAN_STR, SCAN_ESC, SCAN_HEX, SCAN_PAIR_BS, SCAN_PAIR_U, SCAN_LOW_HEX
  } scan_e;

  // How a table row is checked: by the model, no result, or one typed result
  typedef enum logic [1:0] {ROW_MODEL, ROW_NONE, ROW_ONE} row_kind_e;

  typedef struct {
    logic [7:0] src_byte;
    logic       eos;
    row_kind_e  kind;
    logic [7:0] exp_byte;
    logic [3:0] exp_status;
  } row_t;

  logic clk;
  logic rst_n;

  juu_src_if src_if ();
  juu_res_if res_if ();

  json_string_unescape_utf8_unit i_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .src_i  (src_if),
    .res_o  (res_if)
  );

  // Decoder model state
  scan_e       scan_mode;
  int unsigned digit_cnt;
  logic [15:0] unit_acc;
  logic [9:0]  high_half;

  // Results of one source transaction, before they join the queue
  logic [7:0] burst_byte [MAX_RES];
  logic [3:0] burst_status [MAX_RES];
  int         burst_n;

  result_t     pending_out_q [$];
  row_t        directed_rows [N_ROWS];
  int unsigned mismatch_cnt;
  int unsigned src_cnt;
  int unsigned cycle_cnt;
  bit          send_calm;
  bit          recv_calm;

  // --------------------------------------------------------------------------
  // Decoder model
  // --------------------------------------------------------------------------
  function void put_result(input logic [7:0] b, input logic [3:0] st);
    if (burst_n < int'(MAX_RES)) begin
      burst_byte[burst_n]   = b;
      burst_status[burst_n] = st;
      burst_n++;
    end
  endfunction

  function void reset_scan();
    scan_mode = SCAN_WAIT;
    digit_cnt = 0;
    unit_acc  = '0;
    high_half = '0;
  endfunction

  function void fail_scan(input logic [3:0] st);
    put_result(8'h00, st);
    reset_scan();
  endfunction

  function automatic int hex_val(input logic [7:0] c);
    if (c >= CH_ZERO && c <= CH_ZERO + 8'd9) return int'(c - CH_ZERO);
    if (c >= CH_LC_A && c <= CH_LC_A + 8'd5) return int'(c - CH_LC_A) + 10;
    if (c >= CH_UC_A && c <= CH_UC_A + 8'd5) return int'(c - CH_UC_A) + 10;
    return -1;
  endfunction

  function void put_utf8(input logic [20:0] cp);
    if (cp < 21'h80) begin
      put_result(cp[7:0], ST_DATA);
    end else if (cp < 21'h800) begin
      put_result({3'b110, cp[10:6]}, ST_DATA);
      put_result({2'b10, cp[5:0]}, ST_DATA);
    end else if (cp < 21'h10000) begin
      put_result({4'b1110, cp[15:12]}, ST_DATA);
      put_result({2'b10, cp[11:6]}, ST_DATA);
      put_result({2'b10, cp[5:0]}, ST_DATA);
    end else begin
      put_result({5'b11110, cp[20:18]}, ST_DATA);
      put_result({2'b10, cp[17:12]}, ST_DATA);
      put_result({2'b10, cp[11:6]}, ST_DATA);
      put_result({2'b10, cp[5:0]}, ST_DATA);
    end
  endfunction

  // Shift in one hex digit; true once four digits form a code unit
  function bit take_digit(input logic [7:0] c);
    int h;
    h = hex_val(c);
    if (h < 0) begin
      fail_scan(ST_BAD_HEX);
      return 1'b0;
    end
    unit_acc  = {unit_acc[11:0], h[3:0]};
    digit_cnt = digit_cnt + 1;
    return digit_cnt >= 4;
  endfunction

  // Advance the model by one source transaction and fill the burst
  function void unescape_step(input logic [7:0] c, input logic eos);
    logic [15:0] cu;
    burst_n = 0;
    if (eos) begin
      case (scan_mode)
        SCAN_STR, SCAN_ESC:                      fail_scan(ST_UNTERM);
        SCAN_HEX:                                fail_scan(ST_SHORT_U);
        SCAN_PAIR_BS, SCAN_PAIR_U, SCAN_LOW_HEX: fail_scan(ST_UNPAIRED);
        default:                                 fail_scan(ST_NO_QUOTE);
      endcase
    end else begin
      case (scan_mode)
        SCAN_STR: begin
          if (c == CH_QUOTE) begin
            put_result(8'h00, ST_CLOSED);
            reset_scan();
          end else if (c < CH_SPACE) begin
            fail_scan(ST_CONTROL);
          end else if (c == CH_BSLASH) begin
            scan_mode = SCAN_ESC;
          end else begin
            put_result(c, ST_DATA);
          end
        end
        SCAN_ESC: begin
          scan_mode = SCAN_STR;
          case (c)
            CH_QUOTE, CH_BSLASH, CH_SLASH: put_result(c, ST_DATA);
            CH_B: put_result(BY_BS, ST_DATA);
            CH_F: put_result(BY_FF, ST_DATA);
            CH_N: put_result(BY_LF, ST_DATA);
            CH_R: put_result(BY_CR, ST_DATA);
            CH_T: put_result(BY_TAB, ST_DATA);
            CH_U: begin
              scan_mode = SCAN_HEX;
              digit_cnt = 0;
              unit_acc  = '0;
            end
            default: fail_scan(ST_BAD_ESC);
          endcase
        end
        SCAN_HEX: begin
          if (take_digit(c)) begin
            cu        = unit_acc;
            digit_cnt = 0;
            unit_acc  = '0;
            if (cu[15:10] == SURR_HIGH) begin
              high_half = cu[9:0];
              scan_mode = SCAN_PAIR_BS;
            end else if (cu[15:10] == SURR_LOW) begin
              fail_scan(ST_LONE_LOW);
            end else begin
              put_utf8({5'd0, cu});
              scan_mode = SCAN_STR;
            end
          end
        end
        SCAN_PAIR_BS: begin
          if (c == CH_BSLASH) scan_mode = SCAN_PAIR_U;
          else fail_scan(ST_UNPAIRED);
        end
        SCAN_PAIR_U: begin
          if (c == CH_U) begin
            scan_mode = SCAN_LOW_HEX;
            digit_cnt = 0;
            unit_acc  = '0;
          end else begin
            fail_scan(ST_UNPAIRED);
          end
        end
        SCAN_LOW_HEX: begin
          if (take_digit(c)) begin
            cu = unit_acc;
            if (cu[15:10] != SURR_LOW) begin
              fail_scan(ST_BAD_LOW);
            end else begin
              put_utf8(21'h10000 + {high_half, cu[9:0]});
              reset_scan();
              scan_mode = SCAN_STR;
            end
          end
        end
        default: begin
          if (c == CH_QUOTE) begin
            reset_scan();
            scan_mode = SCAN_STR;
          end else begin
            fail_scan(ST_NO_QUOTE);
          end
        end
      endcase
    end
  endfunction

  // Append one expected result to the tail of the queue
  function void queue_result(input result_t r);
    pending_out_q = {pending_out_q, r};
  endfunction

  // --------------------------------------------------------------------------
  // Source side
  // --------------------------------------------------------------------------
  // Drive one source transaction after a random gap and queue its results
  task automatic send_src(input logic [7:0] b, input logic eos,
                          input row_kind_e kind = ROW_MODEL,
                          input logic [7:0] exp_byte = 8'h00,
                          input logic [3:0] exp_status = ST_DATA);
    int unsigned gap;
    gap = send_calm ? 0 : $urandom_range(0, 7);
    @(negedge clk);
    if (gap > 0) begin
      src_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    src_if.valid         <= 1'b1;
    src_if.source_byte   <= b;
    src_if.end_of_source <= eos;
    do @(posedge clk); while (src_if.ready !== 1'b1);
    unescape_step(b, eos);
    src_cnt++;
    case (kind)
      ROW_ONE:  queue_result('{exp_byte, exp_status, 1'b1});
      ROW_NONE: ;
      default: begin
        for (int i = 0; i < burst_n; i++) begin
          queue_result('{burst_byte[i], burst_status[i], i == burst_n - 1});
        end
      end
    endcase
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] d);
    if (d < 4'd10) return CH_ZERO + 8'(d);
    return ($urandom_range(0, 1) ? CH_LC_A : CH_UC_A) + 8'(d) - 8'd10;
  endfunction

  // Send the leading cnt hex digits of a code unit, mixed case
  task automatic send_hex_digits(input logic [15:0] unit, input int cnt);
    for (int i = 3; i > 3 - cnt; i--) send_src(hex_char(unit[i*4 +: 4]), 1'b0);
  endtask

  task automatic send_u_unit(input logic [15:0] unit);
    send_src(CH_BSLASH, 1'b0);
    send_src(CH_U, 1'b0);
    send_hex_digits(unit, 4);
  endtask

  function automatic logic [15:0] rand_high();
    if ($urandom_range(0, 3) == 0) return $urandom_range(0, 1) ? 16'hDBFF : 16'hD800;
    return {SURR_HIGH, 10'($urandom_range(0, 1023))};
  endfunction

  function automatic logic [15:0] rand_low();
    if ($urandom_range(0, 3) == 0) return $urandom_range(0, 1) ? 16'hDFFF : 16'hDC00;
    return {SURR_LOW, 10'($urandom_range(0, 1023))};
  endfunction

  function automatic logic [7:0] rand_non_hex();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (hex_val(c) >= 0);
    return c;
  endfunction

  // One string body element: plain byte, simple escape, \u code point, pair
  task automatic send_element();
    logic [7:0]  c;
    logic [15:0] unit;
    logic [7:0]  esc_letters [8];
    logic [15:0] edge_units [7];
    esc_letters = '{CH_QUOTE, CH_BSLASH, CH_SLASH, CH_B, CH_F, CH_N, CH_R, CH_T};
    edge_units  = '{16'h0000, 16'h007F, 16'h0080, 16'h07FF, 16'h0800, 16'hD7FF, 16'hFFFF};
    case ($urandom_range(0, 6))
      0, 1: begin
        do c = 8'($urandom_range(CH_SPACE, 255)); while (c == CH_QUOTE || c == CH_BSLASH);
        send_src(c, 1'b0);
      end
      2: begin
        send_src(CH_BSLASH, 1'b0);
        send_src(esc_letters[$urandom_range(0, 7)], 1'b0);
      end
      3: send_u_unit(16'($urandom_range(0, 16'h7F)));
      4: send_u_unit(16'($urandom_range(16'h80, 16'h7FF)));
      5: begin
        if ($urandom_range(0, 2) == 0) begin
          unit = edge_units[$urandom_range(0, 6)];
        end else begin
          do unit = 16'($urandom_range(16'h800, 16'hFFFF)); while (unit[15:11] == 5'b11011);
        end
        send_u_unit(unit);
      end
      default: begin
        send_u_unit(rand_high());
        send_u_unit(rand_low());
      end
    endcase
  endtask

  // A random string: optional noise, opening quote, body, then an ending
  task automatic send_random_string();
    logic [7:0]  c;
    logic [15:0] unit;
    int          part;
    if ($urandom_range(0, 5) == 0) send_calm = ~send_calm;
    // noise while waiting for the opening quote
    if ($urandom_range(0, 5) == 0) begin
      if ($urandom_range(0, 2) == 0) begin
        send_src(8'($urandom_range(0, 255)), 1'b1);
      end else begin
        do c = 8'($urandom_range(0, 255)); while (c == CH_QUOTE);
        send_src(c, 1'b0);
      end
    end
    send_src(CH_QUOTE, 1'b0);
    repeat ($urandom_range(0, 10)) send_element();
    case ($urandom_range(0, 15))
      8: send_src(8'($urandom_range(0, CH_SPACE - 1)), 1'b0);
      9: begin
        send_src(CH_BSLASH, 1'b0);
        do c = 8'($urandom_range(0, 255));
        while (c inside {CH_QUOTE, CH_BSLASH, CH_SLASH, CH_B, CH_F, CH_N, CH_R, CH_T, CH_U});
        send_src(c, 1'b0);
      end
      10: begin
        // bad digit in the first unit or in the low half of a pair
        if ($urandom_range(0, 1)) send_src(CH_BSLASH, 1'b0);
        else begin
          send_u_unit(rand_high());
          send_src(CH_BSLASH, 1'b0);
        end
        send_src(CH_U, 1'b0);
        send_hex_digits(16'($urandom_range(0, 16'hFFFF)), $urandom_range(0, 3));
        send_src(rand_non_hex(), 1'b0);
      end
      11: send_u_unit(rand_low());
      12: begin
        send_u_unit(rand_high());
        part = $urandom_range(0, 3);
        if (part == 0) unit = 16'hDBFF;
        else if (part == 1) unit = 16'hE000;
        else do unit = 16'($urandom_range(0, 16'hFFFF)); while (unit[15:10] == SURR_LOW);
        send_u_unit(unit);
      end
      13: begin
        send_u_unit(rand_high());
        if ($urandom_range(0, 1)) begin
          do c = 8'($urandom_range(0, 255)); while (c == CH_BSLASH);
        end else begin
          send_src(CH_BSLASH, 1'b0);
          do c = 8'($urandom_range(0, 255)); while (c == CH_U);
        end
        send_src(c, 1'b0);
      end
      14, 15: begin
        // end of source at a random depth of an escape
        part = $urandom_range(0, 5);
        if (part == 1) send_src(CH_BSLASH, 1'b0);
        if (part == 2) begin
          send_src(CH_BSLASH, 1'b0);
          send_src(CH_U, 1'b0);
          send_hex_digits(16'($urandom_range(0, 16'hFFFF)), $urandom_range(0, 3));
        end
        if (part >= 3) send_u_unit(rand_high());
        if (part >= 4) send_src(CH_BSLASH, 1'b0);
        if (part == 5) begin
          send_src(CH_U, 1'b0);
          send_hex_digits(rand_low(), $urandom_range(0, 3));
        end
        send_src(8'($urandom_range(0, 255)), 1'b1);
      end
      default: send_src(CH_QUOTE, 1'b0);
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Clock, watchdog
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("tb_json_string_unescape_utf8_unit: done, errors");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Result side: random stalls, compare each transaction with the queue head
  // --------------------------------------------------------------------------
  initial begin : result_sink
    int unsigned stall;
    result_t     want;
    res_if.ready = 1'b0;
    forever begin
      if ($urandom_range(0, 31) == 0) recv_calm = ~recv_calm;
      stall = recv_calm ? 0 : $urandom_range(0, 7);
      @(negedge clk);
      if (stall > 0) begin
        res_if.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      res_if.ready <= 1'b1;
      do @(posedge clk); while (res_if.valid !== 1'b1);
      if (pending_out_q.size() == 0) begin
        $error("unexpected result: out_byte %h status %0d last_of_run %b",
               res_if.out_byte, res_if.status, res_if.last_of_run);
        mismatch_cnt++;
      end else begin
        want = pending_out_q.pop_front();
        if (res_if.out_byte !== want.out_byte) begin
          $error("out_byte: expected %h, got %h", want.out_byte, res_if.out_byte);
          mismatch_cnt++;
        end
        if (res_if.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, res_if.status);
          mismatch_cnt++;
        end
        if (res_if.last_of_run !== want.last_of_run) begin
          $error("last_of_run: expected %b, got %b", want.last_of_run, res_if.last_of_run);
          mismatch_cnt++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus: reset, directed table, random strings, drain
  // --------------------------------------------------------------------------
  initial begin : source_driver
    int unsigned str_cnt;
    src_if.valid         = 1'b0;
    src_if.source_byte   = 8'h00;
    src_if.end_of_source = 1'b0;
    rst_n                = 1'b0;
    cycle_cnt            = 0;
    mismatch_cnt         = 0;
    send_calm            = 1'b0;
    recv_calm            = 1'b0;
    reset_scan();

    directed_rows = '{
      // waiting for a quote after reset: stray byte, then end of source
      '{CH_LC_A,   1'b0, ROW_ONE,   8'h00,    ST_NO_QUOTE},
      '{8'h00,     1'b1, ROW_ONE,   8'h00,    ST_NO_QUOTE},
      // plain byte extremes and a control byte
      '{CH_QUOTE,  1'b0, ROW_NONE,  8'h00,    ST_DATA},
      '{CH_SPACE,  1'b0, ROW_ONE,   CH_SPACE, ST_DATA},
      '{8'hFF,     1'b0, ROW_ONE,   8'hFF,    ST_DATA},
      '{8'h00,     1'b0, ROW_ONE,   8'h00,    ST_CONTROL},
      // simple escape, then an unknown escape letter
      '{CH_QUOTE,  1'b0, ROW_NONE,  8'h00,    ST_DATA},
      '{CH_BSLASH, 1'b0, ROW_NONE,  8'h00,    ST_DATA},
      '{CH_T,      1'b0, ROW_ONE,   BY_TAB,   ST_DATA},
      '{CH_BSLASH, 1'b0, ROW_NONE,  8'h00,    ST_DATA},
      '{8'h78,     1'b0, ROW_ONE,   8'h00,    ST_BAD_ESC},
      // highest code point: \udbff\uDFFF
      '{CH_QUOTE,  1'b0, ROW_NONE,  8'h00,    ST_DATA},
      '{CH_BSLASH, 1'b0, ROW_NONE,  8'h00,    ST_DATA},
      '{CH_U,      1'b0, ROW_NONE,  8'h00,    ST_DATA},
      '{8'h64,     1'b0, ROW_MODEL, 8'h00,    ST_DATA},
      '{CH_B,      1'b0, ROW_MODEL, 8'h00,    ST_DATA},
      '{CH_F,      1'b0, ROW_MODEL, 8'h00,    ST_DATA},
      '{CH_F,      1'b0, ROW_MODEL, 8'h00,    ST_DATA},
      '{CH_BSLASH, 1'b0, ROW_MODEL, 8'h00,    ST_DATA},
      '{CH_U,      1'b0, ROW_MODEL, 8'h00,    ST_DATA},
      '{8'h44,     1'b0, ROW_MODEL, 8'h00,    ST_DATA},
      '{8'h46,     1'b0, ROW_MODEL, 8'h00,    ST_DATA},
      '{8'h46,     1'b0, ROW_MODEL, 8'h00,    ST_DATA},
      '{8'h46,     1'b0, ROW_MODEL, 8'h00,    ST_DATA},
      // non-hex digit in a \u escape
      '{CH_BSLASH, 1'b0, ROW_NONE,  8'h00,    ST_DATA},
      '{CH_U,      1'b0, ROW_NONE,  8'h00,    ST_DATA},
      '{8'h67,     1'b0, ROW_ONE,   8'h00,    ST_BAD_HEX},
      // open a string and end the source inside it
      '{CH_QUOTE,  1'b0, ROW_NONE,  8'h00,    ST_DATA},
      '{8'h00,     1'b1, ROW_ONE,   8'h00,    ST_UNTERM}
    };

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < int'(N_ROWS); i++) begin
      send_src(directed_rows[i].src_byte, directed_rows[i].eos, directed_rows[i].kind,
               directed_rows[i].exp_byte, directed_rows[i].exp_status);
    end

    // hold the source until the directed results have drained
    @(negedge clk);
    src_if.valid <= 1'b0;
    while (pending_out_q.size() != 0) @(posedge clk);

    src_cnt = 0;
    str_cnt = 0;
    while (src_cnt < RANDOM_ITEMS) begin
      send_random_string();
      str_cnt++;
      if (str_cnt % 20 == 0) begin
        @(negedge clk);
        src_if.valid <= 1'b0;
        while (pending_out_q.size() != 0) @(posedge clk);
      end
    end

    // drain, then let a few more cycles pass for stray results
    @(negedge clk);
    src_if.valid <= 1'b0;
    while (pending_out_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatch_cnt == 0) begin
      $display("tb_json_string_unescape_utf8_unit: done, clean");
    end else begin
      $display("tb_json_string_unescape_utf8_unit: done, errors");
    end
    $finish;
  end

endmodule
